// ----- rtl/pmst_pkg.sv -----
// ----------------------------------------------------------------------------
// pmst_pkg
// shared widths, constants, stream item types and matrix addressing for the
// prim minimum spanning tree block
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int MAT_AW       = $clog2(MAT_DEPTH);

  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int KEY_W    = WEIGHT_W + 1;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [KEY_W-1:0] KEY_INF  = {1'b1, {WEIGHT_W{1'b0}}};
  localparam logic [CNT_W-1:0] VC_RESET = 7'd64;

  typedef struct packed {
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } pmst_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    parent;
    logic [IDX_W-1:0]    child;
    logic [WEIGHT_W-1:0] weight;
    logic                unreachable;
    logic                last;
  } pmst_res_t;

  function automatic logic [MAT_AW-1:0] mat_addr(input logic [VTX_W-1:0] r,
                                                 input logic [VTX_W-1:0] c);
    return MAT_AW'(r) * MAT_AW'(MAX_VERTICES) + MAT_AW'(c);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pmst_ram.sv -----
// ----------------------------------------------------------------------------
// pmst_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pmst_core.sv -----
// ----------------------------------------------------------------------------
// pmst_core
// matrix store and prim sequencer: pipelined key scans through one shared
// comparator, then per-vertex readout of the tree edges
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire pmst_pkg::pmst_item_t      in_item,
  input  wire logic [pmst_pkg::VTX_W-1:0] n_last,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output pmst_pkg::pmst_res_t            res
);

  import pmst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RELAX,
    S_PAR,
    S_MAT,
    S_OUT
  } state_t;

  state_t                  state;
  logic [VTX_W-1:0]        cnt;
  logic                    iss;
  logic                    rd_vld;
  logic [VTX_W-1:0]        rd_idx;
  logic [VTX_W-1:0]        u;
  logic [KEY_W-1:0]        best;
  logic [VTX_W-1:0]        best_u;
  logic                    found;
  logic [MAX_VERTICES-1:0] in_tree;
  logic [MAX_VERTICES-1:0] key_vld;

  logic                    accept;
  logic                    in_range;
  logic                    mat_we;
  logic [MAT_AW-1:0]       mat_wa;
  logic                    mat_re;
  logic [MAT_AW-1:0]       mat_ra;
  logic [WEIGHT_W-1:0]     w_rd;
  logic                    key_re;
  logic                    key_we;
  logic [WEIGHT_W-1:0]     key_rd;
  logic                    par_re;
  logic [VTX_W-1:0]        par_rd;
  logic [KEY_W-1:0]        key_cur;
  logic [KEY_W-1:0]        cmp_a;
  logic [KEY_W-1:0]        cmp_b;
  logic                    lt;
  logic                    take;
  logic                    phase_end;
  logic [VTX_W-1:0]        pick_u;
  logic                    pick_found;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (CNT_W'(in_item.row) < CNT_W'(MAX_VERTICES)) &&
                    (CNT_W'(in_item.col) < CNT_W'(MAX_VERTICES));

  assign mat_we = accept && in_range;
  assign mat_wa = mat_addr(in_item.row[VTX_W-1:0], in_item.col[VTX_W-1:0]);
  assign mat_re = ((state == S_RELAX) && iss) || (state == S_MAT);
  assign mat_ra = (state == S_MAT) ? mat_addr(par_rd, cnt) : mat_addr(u, cnt);

  assign key_re = ((state == S_SEARCH) || (state == S_RELAX)) && iss;
  assign par_re = (state == S_PAR);

  // shared comparator: key scan in search, edge relaxation in relax
  always_comb begin
    if (key_vld[rd_idx]) begin
      key_cur = {1'b0, key_rd};
    end else if (rd_idx == '0) begin
      key_cur = '0;
    end else begin
      key_cur = KEY_INF;
    end
    cmp_a = (state == S_RELAX) ? {1'b0, w_rd} : key_cur;
    cmp_b = (state == S_RELAX) ? key_cur : best;
    lt    = (cmp_a < cmp_b);
    take  = rd_vld && !in_tree[rd_idx] && lt &&
            ((state != S_RELAX) || (w_rd != '0));
  end

  assign key_we     = (state == S_RELAX) && take;
  assign phase_end  = rd_vld && (rd_idx == n_last);
  assign pick_u     = take ? rd_idx : best_u;
  assign pick_found = found || take;

  pmst_ram #(.DEPTH(MAT_DEPTH), .WIDTH(WEIGHT_W)) u_mat (
    .clk     (clk),
    .wr_en   (mat_we),
    .wr_addr (mat_wa),
    .wr_data (in_item.weight),
    .rd_en   (mat_re),
    .rd_addr (mat_ra),
    .rd_data (w_rd)
  );

  pmst_ram #(.DEPTH(MAX_VERTICES), .WIDTH(WEIGHT_W)) u_key (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (rd_idx),
    .wr_data (w_rd),
    .rd_en   (key_re),
    .rd_addr (cnt),
    .rd_data (key_rd)
  );

  pmst_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VTX_W)) u_par (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (rd_idx),
    .wr_data (u),
    .rd_en   (par_re),
    .rd_addr (cnt),
    .rd_data (par_rd)
  );

  assign res_valid       = (state == S_OUT);
  assign res.child       = IDX_W'(cnt);
  assign res.parent      = in_tree[cnt] ? IDX_W'(par_rd) : '0;
  assign res.weight      = in_tree[cnt] ? w_rd : '0;
  assign res.unreachable = !in_tree[cnt];
  assign res.last        = (cnt == n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      iss     <= 1'b0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
      in_tree <= '0;
      key_vld <= '0;
    end else begin
      rd_vld <= iss;
      rd_idx <= cnt;
      if (iss) begin
        if (cnt == n_last) begin
          iss <= 1'b0;
        end else begin
          cnt <= cnt + VTX_W'(1);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_item.last) begin
            in_tree <= '0;
            key_vld <= '0;
            state   <= S_SEARCH;
            iss     <= 1'b1;
            cnt     <= '0;
            best    <= KEY_INF;
            best_u  <= '0;
            found   <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (take) begin
            best   <= key_cur;
            best_u <= rd_idx;
            found  <= 1'b1;
          end
          if (phase_end) begin
            if (pick_found) begin
              in_tree[pick_u] <= 1'b1;
              u               <= pick_u;
              state           <= S_RELAX;
              iss             <= 1'b1;
              cnt             <= '0;
            end else if (n_last == '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_PAR;
              cnt   <= VTX_W'(1);
            end
          end
        end
        S_RELAX: begin
          if (take) begin
            key_vld[rd_idx] <= 1'b1;
          end
          if (phase_end) begin
            state  <= S_SEARCH;
            iss    <= 1'b1;
            cnt    <= '0;
            best   <= KEY_INF;
            best_u <= '0;
            found  <= 1'b0;
          end
        end
        S_PAR: begin
          state <= S_MAT;
        end
        S_MAT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            if (cnt == n_last) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + VTX_W'(1);
              state <= S_PAR;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_vertex_per_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX && $past(state) == S_SEARCH) |->
      ($countones(in_tree) == $countones($past(in_tree)) + 1))
    else $error("tree did not grow by exactly one vertex");

  a_key_write_in_relax: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (state == S_RELAX && rd_vld && w_rd != '0))
    else $error("key write outside relaxation");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (state == S_IDLE))
    else $error("sequencer busy after final edge");

  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!iss && !rd_vld))
    else $error("request taken while a scan is in flight");

  a_child_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.child != '0))
    else $error("root vertex reported as child");
`endif

endmodule

`default_nettype wire

// ----- rtl/prim_minimum_spanning_tree.sv -----
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// prim minimum spanning tree over a dense adjacency matrix loaded entry by
// entry; reports the tree edge of every vertex 1..n-1
//
// channel  dir  handshake              contents
// s_*      in   s_tvalid / s_tready    one matrix entry, tlast starts the run
// m_*      out  m_tvalid / m_tready    one tree edge, tlast on vertex n-1
// cfg_*    in   cfg_valid / cfg_ready  vertex_count
//
// loading accepts one entry per cycle while s_tready is high; a run then makes
// key scans and relaxation passes through the shared comparator, then for each
// reported edge a parent ram read, a matrix ram read and an output handoff.
// s_tready stays low for the whole run. reset is synchronous; the matrix is
// undefined until written and needs no clearing pass. a stalled m_tready holds
// the output register and then the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module prim_minimum_spanning_tree (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // row_index[5:0], col_index[11:6], edge_weight[27:12], zero fill
  input  wire logic [pmst_pkg::DATA_W-1:0] s_tdata,
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // parent_vertex[5:0], child_vertex[11:6], tree_weight[27:12], zero fill
  output logic      [pmst_pkg::DATA_W-1:0] m_tdata,
  // unreachable[0]
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pmst_pkg::CNT_W-1:0]  cfg_data
);

  import pmst_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  logic [VTX_W-1:0] n_last;
  pmst_item_t       item;
  pmst_res_t        res;
  logic             res_valid;
  logic             res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // zero acts as one vertex, anything above the maximum as the maximum
  always_comb begin
    if (vertex_count == '0) begin
      n_last = '0;
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      n_last = VTX_W'(MAX_VERTICES - 1);
    end else begin
      n_last = VTX_W'(vertex_count - CNT_W'(1));
    end
  end

  assign item.row    = s_tdata[IDX_W-1:0];
  assign item.col    = s_tdata[2*IDX_W-1:IDX_W];
  assign item.weight = s_tdata[2*IDX_W+WEIGHT_W-1:2*IDX_W];
  assign item.last   = s_tlast;

  pmst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .n_last    (n_last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= DATA_W'({res.weight, res.child, res.parent});
      m_tuser <= res.unreachable;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire
